// ===== rtl/npcs_pkg.sv =====
package npcs_pkg;

  localparam int unsigned COLOR_W = 8;
  localparam int unsigned SQ_W    = 16;
  // 3 * 255 * 255 fits in 18 bits
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned INDEX_W = 8;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

endpackage

// ===== rtl/nearest_palette_color_search.sv =====
// a load writes the palette RAM at its transfer; a pixel scans the entries in index order
// through the RAM read register, the squares register and the sum and compare, up to the
// last entry or the first exact match, and loads the index into the output register
// throughput: loads one per cycle while idle; none while a scan runs or its result is held
// reset: rst_ni clears control state asynchronously; palette contents stay undefined
// until loaded
module nearest_palette_color_search #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [npcs_pkg::INDEX_W-1:0]    entry_index_i,
  input  logic [npcs_pkg::COLOR_W-1:0]    red_i,
  input  logic [npcs_pkg::COLOR_W-1:0]    green_i,
  input  logic [npcs_pkg::COLOR_W-1:0]    blue_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [npcs_pkg::INDEX_W-1:0]    color_index_o
);

  localparam int unsigned IdxW  = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CntW  = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PALETTE_ENTRIES - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state_q, state_d;

  // input transfer decode
  logic in_xfer, load_xfer, pixel_xfer, load_in_range;
  npcs_pkg::rgb_t in_rgb;

  // scan pipeline: issue -> read data -> squares -> sum and compare
  logic [CntW-1:0] iss_cnt_q;
  logic            issue;
  logic            v1_q, v2_q;
  logic [IdxW-1:0] idx1_q, idx2_q;
  npcs_pkg::rgb_t  pix_q;
  npcs_pkg::rgb_t  ent_rd;
  logic [npcs_pkg::DIST_W-1:0] cur_dist;
  logic [npcs_pkg::DIST_W-1:0] best_dist_q;
  logic [IdxW-1:0] best_idx_q;
  logic [IdxW-1:0] res_q;

  logic hit, better, last, finish;
  logic [IdxW-1:0] fin_idx;

  // output register
  logic                         out_valid_q;
  logic [npcs_pkg::INDEX_W-1:0] color_index_q;
  logic                         out_free;
  logic                         out_load;
  logic [IdxW-1:0]              out_idx;

  assign in_ready_o    = (state_q == S_IDLE);
  assign in_xfer       = in_valid_i & in_ready_o;
  assign in_rgb        = '{red: red_i, green: green_i, blue: blue_i};
  assign load_in_range = ({1'b0, entry_index_i} < 9'(PALETTE_ENTRIES));
  // loads beyond the palette are dropped
  assign load_xfer     = in_xfer & (op_i == npcs_pkg::OP_LOAD) & load_in_range;
  assign pixel_xfer    = in_xfer & (op_i == npcs_pkg::OP_PIXEL);

  // one read per cycle while entries remain to be issued
  assign issue = (state_q == S_SCAN) & (iss_cnt_q < CntW'(PALETTE_ENTRIES));

  npcs_palette_ram #(
    .Depth (PALETTE_ENTRIES),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (load_xfer),
    .waddr_i (entry_index_i[IdxW-1:0]),
    .wdata_i (in_rgb),
    .re_i    (issue),
    .raddr_i (iss_cnt_q[IdxW-1:0]),
    .rdata_o (ent_rd)
  );

  npcs_dist_unit u_dist (
    .clk_i  (clk_i),
    .en_i   (v1_q),
    .pix_i  (pix_q),
    .ent_i  (ent_rd),
    .dist_o (cur_dist)
  );

  // exact match ends the scan; otherwise strict less-than keeps the earliest minimum
  assign hit     = v2_q & (cur_dist == '0);
  assign better  = cur_dist < best_dist_q;
  assign last    = v2_q & (idx2_q == LastIdx);
  assign finish  = (state_q == S_SCAN) & (hit | last);
  assign fin_idx = (hit | better) ? idx2_q : best_idx_q;

  assign out_free = ~out_valid_q | out_ready_i;
  assign out_load = ((state_q == S_SCAN) & finish | (state_q == S_HOLD)) & out_free;
  assign out_idx  = (state_q == S_HOLD) ? res_q : fin_idx;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (pixel_xfer) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_d = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_cnt_q   <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pixel_xfer) begin
        iss_cnt_q <= '0;
      end else if (issue) begin
        iss_cnt_q <= iss_cnt_q + CntW'(1);
      end
      // flush reads still in flight once the answer is known
      v1_q <= issue & ~finish;
      v2_q <= v1_q & ~finish;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pixel_xfer) begin
      pix_q       <= in_rgb;
      best_dist_q <= '1;
    end else if (v2_q & better) begin
      best_dist_q <= cur_dist;
      best_idx_q  <= idx2_q;
    end
    idx1_q <= iss_cnt_q[IdxW-1:0];
    idx2_q <= idx1_q;
    if (finish) begin
      res_q <= fin_idx;
    end
    if (out_load) begin
      color_index_q <= npcs_pkg::INDEX_W'(out_idx);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = color_index_q;

endmodule

// ===== rtl/npcs_palette_ram.sv =====
module npcs_palette_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  npcs_pkg::rgb_t       wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output npcs_pkg::rgb_t       rdata_o
);

  npcs_pkg::rgb_t mem [Depth];
  npcs_pkg::rgb_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/npcs_dist_unit.sv =====
module npcs_dist_unit (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  npcs_pkg::rgb_t                pix_i,
  input  npcs_pkg::rgb_t                ent_i,
  output logic [npcs_pkg::DIST_W-1:0]   dist_o
);

  logic [npcs_pkg::COLOR_W-1:0] dr, dg, db;
  logic [npcs_pkg::SQ_W-1:0]    sq_r_d, sq_g_d, sq_b_d;
  logic [npcs_pkg::SQ_W-1:0]    sq_r_q, sq_g_q, sq_b_q;

  // absolute component differences and their squares
  always_comb begin
    dr = (pix_i.red >= ent_i.red) ? pix_i.red - ent_i.red : ent_i.red - pix_i.red;
    dg = (pix_i.green >= ent_i.green) ? pix_i.green - ent_i.green
                                      : ent_i.green - pix_i.green;
    db = (pix_i.blue >= ent_i.blue) ? pix_i.blue - ent_i.blue : ent_i.blue - pix_i.blue;
    sq_r_d = {8'b0, dr} * {8'b0, dr};
    sq_g_d = {8'b0, dg} * {8'b0, dg};
    sq_b_d = {8'b0, db} * {8'b0, db};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_r_q <= sq_r_d;
      sq_g_q <= sq_g_d;
      sq_b_q <= sq_b_d;
    end
  end

  assign dist_o = npcs_pkg::DIST_W'(sq_r_q) + npcs_pkg::DIST_W'(sq_g_q)
                + npcs_pkg::DIST_W'(sq_b_q);

endmodule

// ===== bench/tb_nearest_palette_color_search.sv =====
module tb_nearest_palette_color_search;

  localparam int unsigned PAL_N        = 256;
  localparam int unsigned RANDOM_ITEMS = 1750;
  // a pixel scan, a long result stall and a long sender gap all fit well below this
  localparam int unsigned IDLE_LIMIT   = 4000;

  // one request as the sender presents it; drain makes the sender wait for all results
  typedef struct {
    logic                           op;
    logic [npcs_pkg::INDEX_W-1:0]   idx;
    npcs_pkg::rgb_t                 color;
    bit                             drain;
  } palette_req_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         op_i = npcs_pkg::OP_LOAD;
  logic [npcs_pkg::INDEX_W-1:0] entry_index_i = '0;
  logic [npcs_pkg::COLOR_W-1:0] red_i = '0;
  logic [npcs_pkg::COLOR_W-1:0] green_i = '0;
  logic [npcs_pkg::COLOR_W-1:0] blue_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [npcs_pkg::INDEX_W-1:0] color_index_o;

  palette_req_t                 req_queue[$];
  logic [npcs_pkg::INDEX_W-1:0] expected_index_q[$];
  npcs_pkg::rgb_t               palette_model [PAL_N];
  // palette as the generator sees it, used to aim pixels at exact matches
  npcs_pkg::rgb_t               gen_palette [PAL_N];

  bit          in_xfer = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  int unsigned loads_sent = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_checked = 0;
  int unsigned exact_hits = 0;

  nearest_palette_color_search #(
    .PALETTE_ENTRIES(PAL_N)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .color_index_o (color_index_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // scan in index order; first exact hit wins, otherwise first of the smallest distance
  function automatic logic [npcs_pkg::INDEX_W-1:0] nearest_color(npcs_pkg::rgb_t px);
    int                           best_dist;
    int                           sq_dist;
    int                           dr;
    int                           dg;
    int                           db;
    logic [npcs_pkg::INDEX_W-1:0] best;
    best_dist = 32'h7fff_ffff;
    best = '0;
    for (int i = 0; i < PAL_N; i++) begin
      dr = int'(px.red) - int'(palette_model[i].red);
      dg = int'(px.green) - int'(palette_model[i].green);
      db = int'(px.blue) - int'(palette_model[i].blue);
      sq_dist = dr * dr + dg * dg + db * db;
      if (sq_dist == 0) begin
        exact_hits++;
        return npcs_pkg::INDEX_W'(i);
      end
      if (sq_dist < best_dist) begin
        best_dist = sq_dist;
        best = npcs_pkg::INDEX_W'(i);
      end
    end
    return best;
  endfunction

  // small offset around a palette color, clamped to the component range
  function automatic logic [npcs_pkg::COLOR_W-1:0] jitter(logic [npcs_pkg::COLOR_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return npcs_pkg::COLOR_W'(v);
  endfunction

  task automatic queue_req(input logic op, input logic [npcs_pkg::INDEX_W-1:0] idx,
                           input logic [npcs_pkg::COLOR_W-1:0] r,
                           input logic [npcs_pkg::COLOR_W-1:0] g,
                           input logic [npcs_pkg::COLOR_W-1:0] b, input bit drain);
    palette_req_t req;
    req.op = op;
    req.idx = idx;
    req.color = '{red: r, green: g, blue: b};
    req.drain = drain;
    if (op == npcs_pkg::OP_LOAD) gen_palette[idx] = req.color;
    req_queue.push_back(req);
  endtask

  task automatic queue_pixel(input logic [npcs_pkg::COLOR_W-1:0] r,
                             input logic [npcs_pkg::COLOR_W-1:0] g,
                             input logic [npcs_pkg::COLOR_W-1:0] b, input bit drain);
    // entry_index is don't-care for pixels, so it carries random bits
    queue_req(npcs_pkg::OP_PIXEL, npcs_pkg::INDEX_W'($urandom_range(0, 255)), r, g, b,
              drain);
  endtask

  // rewrite the whole palette in one of several styles
  task automatic queue_palette_reload(input int unsigned style);
    npcs_pkg::rgb_t few [4];
    npcs_pkg::rgb_t c;
    for (int k = 0; k < 4; k++) begin
      few[k] = '{red: npcs_pkg::COLOR_W'($urandom), green: npcs_pkg::COLOR_W'($urandom),
                 blue: npcs_pkg::COLOR_W'($urandom)};
    end
    for (int i = 0; i < PAL_N; i++) begin
      case (style)
        0: begin
          c = '{red: npcs_pkg::COLOR_W'($urandom), green: npcs_pkg::COLOR_W'($urandom),
                blue: npcs_pkg::COLOR_W'($urandom)};
        end
        1: begin
          // tightly packed colors: lots of duplicates and distance ties
          c = '{red: npcs_pkg::COLOR_W'(120 + $urandom_range(0, 3)),
                green: npcs_pkg::COLOR_W'(120 + $urandom_range(0, 3)),
                blue: npcs_pkg::COLOR_W'(120 + $urandom_range(0, 3))};
        end
        default: begin
          c = few[$urandom_range(0, 3)];
        end
      endcase
      queue_req(npcs_pkg::OP_LOAD, npcs_pkg::INDEX_W'(i), c.red, c.green, c.blue, 1'b0);
    end
  endtask

  // sample both channels at the rising edge; prediction and checking live here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_xfer = in_valid_i && in_ready_o;
      if (in_xfer) begin
        if (op_i == npcs_pkg::OP_LOAD) begin
          loads_sent++;
          if (entry_index_i < PAL_N) begin
            palette_model[entry_index_i] = '{red: red_i, green: green_i, blue: blue_i};
          end
        end else begin
          pixels_sent++;
          expected_index_q.push_back(nearest_color('{red: red_i, green: green_i,
                                                     blue: blue_i}));
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_index_q.size() == 0) begin
          $display("%0t: color_index transfer with nothing expected, expected none, got %0d",
                   $time, color_index_o);
          error_count++;
        end else begin
          if (color_index_o !== expected_index_q[0]) begin
            $display("%0t: color_index mismatch, expected %0d, got %0d",
                     $time, expected_index_q[0], color_index_o);
            error_count++;
          end
          void'(expected_index_q.pop_front());
          results_checked++;
        end
      end
      // watchdog on cycles without any transfer
      if (in_xfer || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // request driver: holds valid until the transfer, then a random gap
  always @(negedge clk_i) begin : drive_requests
    palette_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_xfer) begin
      // waiting for ready, payload stays put
    end else begin
      if (in_xfer) begin
        if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
        gap_left = calm_in ? 0 : pick_gap();
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (req_queue.size() > 0 &&
                   (!req_queue[0].drain || expected_index_q.size() == 0)) begin
        req = req_queue.pop_front();
        op_i <= req.op;
        entry_index_i <= req.idx;
        red_i <= req.color.red;
        green_i <= req.color.green;
        blue_i <= req.color.blue;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side: random stalls, with calm stretches of steady ready
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 499) == 0) calm_out = !calm_out;
      if (stall_left == 0 && !calm_out && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned pick;
    int unsigned burst;
    int unsigned next_drain;
    int unsigned e;
    logic [npcs_pkg::COLOR_W-1:0] r;
    logic [npcs_pkg::COLOR_W-1:0] g;
    logic [npcs_pkg::COLOR_W-1:0] b;

    // structured 3-3-2 palette, every entry distinct, regular ties between neighbors
    for (int i = 0; i < PAL_N; i++) begin
      queue_req(npcs_pkg::OP_LOAD, npcs_pkg::INDEX_W'(i), npcs_pkg::COLOR_W'((i >> 5) * 36),
                npcs_pkg::COLOR_W'(((i >> 2) & 7) * 36), npcs_pkg::COLOR_W'((i & 3) * 85),
                1'b0);
    end

    // directed: exact hit at first and last entry, ties, corners, duplicates
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd252, 8'd252, 8'd255, 1'b0);
    queue_pixel(8'd18, 8'd18, 8'd0, 1'b0);      // four entries equally near
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);  // nearest but not exact, last entry
    queue_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    queue_pixel(8'd100, 8'd130, 8'd200, 1'b0);
    queue_req(npcs_pkg::OP_PIXEL, 8'd255, 8'd42, 8'd170, 8'd3, 1'b0);
    queue_req(npcs_pkg::OP_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_req(npcs_pkg::OP_LOAD, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);  // duplicate white, entry 0 wins
    queue_req(npcs_pkg::OP_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    queue_req(npcs_pkg::OP_LOAD, 8'd128, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(8'd254, 8'd254, 8'd254, 1'b0);  // tie between two whites, not exact
    queue_req(npcs_pkg::OP_LOAD, 8'd1, 8'd255, 8'd0, 8'd255, 1'b0);
    queue_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    queue_req(npcs_pkg::OP_LOAD, 8'd2, 8'd0, 8'd255, 8'd0, 1'b0);
    queue_pixel(8'd0, 8'd255, 8'd0, 1'b1);      // sender waits for all results first

    // random part: palette rewrites mixed with pixel bursts
    n = 0;
    next_drain = 250;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        queue_palette_reload($urandom_range(0, 2));
        n += PAL_N;
      end else if (pick < 30) begin
        burst = $urandom_range(1, 8);
        for (int k = 0; k < burst; k++) begin
          queue_req(npcs_pkg::OP_LOAD, npcs_pkg::INDEX_W'($urandom_range(0, 255)),
                    npcs_pkg::COLOR_W'($urandom), npcs_pkg::COLOR_W'($urandom),
                    npcs_pkg::COLOR_W'($urandom), 1'b0);
        end
        n += burst;
      end else begin
        burst = $urandom_range(1, 6);
        for (int k = 0; k < burst; k++) begin
          pick = $urandom_range(0, 99);
          e = $urandom_range(0, PAL_N - 1);
          if (pick < 35) begin
            r = gen_palette[e].red;
            g = gen_palette[e].green;
            b = gen_palette[e].blue;
          end else if (pick < 60) begin
            r = jitter(gen_palette[e].red);
            g = jitter(gen_palette[e].green);
            b = jitter(gen_palette[e].blue);
          end else if (pick < 70) begin
            r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          end else begin
            r = npcs_pkg::COLOR_W'($urandom);
            g = npcs_pkg::COLOR_W'($urandom);
            b = npcs_pkg::COLOR_W'($urandom);
          end
          queue_pixel(r, g, b, n >= next_drain);
          if (n >= next_drain) next_drain += 250;
          n++;
        end
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_index_q.size() != 0) @(posedge clk_i);
    // a stray result would show up within one scan
    repeat (PAL_N + 8) @(posedge clk_i);

    if (expected_index_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, got none",
               $time, expected_index_q.size());
      error_count++;
    end
    $display("covered %0d palette loads and %0d pixel lookups under random stalls",
             loads_sent, pixels_sent);
    $display("checked %0d results, %0d of them exact palette hits, %0d errors",
             results_checked, exact_hits, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/npcs_pkg.sv
rtl/npcs_palette_ram.sv
rtl/npcs_dist_unit.sv
rtl/nearest_palette_color_search.sv
bench/tb_nearest_palette_color_search.sv
